// ===== design/bbwr_pkg.sv =====
package bbwr_pkg;

  localparam int CW = 32;
  localparam int RW = CW + 3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_WRAP = 2'd1;
  localparam logic [1:0] MODE_REFLECT = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_VALID = 3'd1;
  localparam logic [2:0] REG_LOW_X = 3'd2;
  localparam logic [2:0] REG_LOW_Y = 3'd3;
  localparam logic [2:0] REG_LOW_Z = 3'd4;
  localparam logic [2:0] REG_HIGH_X = 3'd5;
  localparam logic [2:0] REG_HIGH_Y = 3'd6;
  localparam logic [2:0] REG_HIGH_Z = 3'd7;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] vel_z;
  } particle_in_t;

  typedef struct packed {
    logic signed [CW-1:0] new_pos_x;
    logic signed [CW-1:0] new_pos_y;
    logic signed [CW-1:0] new_pos_z;
    logic signed [CW-1:0] new_vel_x;
    logic signed [CW-1:0] new_vel_y;
    logic signed [CW-1:0] new_vel_z;
    logic changed;
  } particle_out_t;

  typedef struct packed {
    logic act;
    logic wrap_mode;
  } axis_ctl_t;

endpackage

// ===== design/bbwr_axis.sv =====
module bbwr_axis #(
  parameter int REFLECT_LIMIT = 8
) (
  input  logic clk,
  input  logic en,
  input  bbwr_pkg::axis_ctl_t ctl,
  input  logic signed [bbwr_pkg::CW-1:0] pos,
  input  logic signed [bbwr_pkg::CW-1:0] vel,
  input  logic signed [bbwr_pkg::CW-1:0] lo,
  input  logic signed [bbwr_pkg::CW-1:0] hi,
  input  logic [bbwr_pkg::CW-1:0] ext,
  output logic signed [bbwr_pkg::CW-1:0] new_pos,
  output logic signed [bbwr_pkg::CW-1:0] new_vel,
  output logic outside
);
  import bbwr_pkg::*;

  localparam int NS = CW;

  typedef struct packed {
    logic signed [RW-1:0] rv;
    logic signed [CW-1:0] vel;
    logic signed [CW-1:0] pos;
    logic [CW-1:0] rem;
    logic [CW-1:0] dvd;
    logic below;
    logic outside;
    logic refl;
    logic wrap;
  } stage_t;

  stage_t st [0:NS];
  stage_t nxt [0:NS-1];
  stage_t load;

  logic signed [RW-1:0] lo_w;
  logic signed [RW-1:0] hi_w;
  logic signed [RW-1:0] pos_w;

  assign lo_w = RW'(lo);
  assign hi_w = RW'(hi);
  assign pos_w = RW'(pos);

  function automatic logic signed [CW-1:0] sat_abs(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    if (!v[CW-1]) begin
      r = v;
    end else if (v == {1'b1, {(CW-1){1'b0}}}) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  always_comb begin
    logic is_below;
    logic is_out;
    logic signed [CW:0] diff;
    is_below = pos_w < lo_w;
    is_out = is_below || (pos_w > hi_w);
    diff = is_below ? ((CW+1)'(lo) - (CW+1)'(pos)) : ((CW+1)'(pos) - (CW+1)'(lo));
    load.rv = pos_w;
    load.vel = vel;
    load.pos = pos;
    load.rem = '0;
    load.dvd = diff[CW-1:0];
    load.below = is_below;
    load.outside = is_out;
    load.refl = ctl.act && !ctl.wrap_mode && is_out;
    load.wrap = ctl.act && ctl.wrap_mode && is_out;
  end

  // one remainder bit per stage, reflection in the first stages
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic [CW:0] t;
      nxt[k] = st[k];
      t = {st[k].rem, st[k].dvd[CW-1]};
      if (t >= {1'b0, ext}) begin
        t = t - {1'b0, ext};
      end
      nxt[k].rem = t[CW-1:0];
      nxt[k].dvd = {st[k].dvd[CW-2:0], 1'b0};
      if (k < REFLECT_LIMIT && st[k].refl) begin
        if (st[k].rv < lo_w) begin
          nxt[k].rv = (lo_w <<< 1) - st[k].rv;
          nxt[k].vel = sat_abs(st[k].vel);
        end else if (st[k].rv > hi_w) begin
          nxt[k].rv = (hi_w <<< 1) - st[k].rv;
          nxt[k].vel = -sat_abs(st[k].vel);
        end
      end
    end
  end

  logic signed [CW-1:0] wrap_pos;
  logic signed [CW-1:0] clamp_pos;

  always_comb begin
    logic [CW-1:0] adj;
    if (!st[NS].below) begin
      adj = st[NS].rem;
    end else if (st[NS].rem == '0) begin
      adj = '0;
    end else begin
      adj = ext - st[NS].rem;
    end
    wrap_pos = lo + adj;
    if (st[NS].rv < lo_w) begin
      clamp_pos = lo;
    end else if (st[NS].rv > hi_w) begin
      clamp_pos = hi;
    end else begin
      clamp_pos = st[NS].rv[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= load;
      for (int k = 0; k < NS; k++) begin
        st[k+1] <= nxt[k];
      end
      if (st[NS].wrap) begin
        new_pos <= wrap_pos;
      end else if (st[NS].refl) begin
        new_pos <= clamp_pos;
      end else begin
        new_pos <= st[NS].pos;
      end
      new_vel <= st[NS].vel;
      outside <= st[NS].outside;
    end
  end

endmodule

// ===== design/box_boundary_wrap_reflect.sv =====
// pipeline: input register, 32 remainder steps, output register; the wrap
// remainder pipeline sets this depth
// throughput: one particle per cycle; the whole pipeline holds while a valid result at the output is stalled
// reset: synchronous, clears all valid bits and the config registers to zero (mode none)
module box_boundary_wrap_reflect #(
  parameter int REFLECT_LIMIT = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  bbwr_pkg::particle_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output bbwr_pkg::particle_out_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import bbwr_pkg::*;

  localparam int DEPTH = CW + 2;

  logic [1:0] cfg_mode;
  logic cfg_bounds_valid;
  logic signed [CW-1:0] cfg_low [0:2];
  logic signed [CW-1:0] cfg_high [0:2];
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode <= MODE_NONE;
      cfg_bounds_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cfg_low[a] <= '0;
        cfg_high[a] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MODE: cfg_mode <= pwdata[1:0];
        REG_VALID: cfg_bounds_valid <= pwdata[0];
        REG_LOW_X: cfg_low[0] <= pwdata;
        REG_LOW_Y: cfg_low[1] <= pwdata;
        REG_LOW_Z: cfg_low[2] <= pwdata;
        REG_HIGH_X: cfg_high[0] <= pwdata;
        REG_HIGH_Y: cfg_high[1] <= pwdata;
        REG_HIGH_Z: cfg_high[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE: prdata = {30'd0, cfg_mode};
      REG_VALID: prdata = {31'd0, cfg_bounds_valid};
      REG_LOW_X: prdata = cfg_low[0];
      REG_LOW_Y: prdata = cfg_low[1];
      REG_LOW_Z: prdata = cfg_low[2];
      REG_HIGH_X: prdata = cfg_high[0];
      REG_HIGH_Y: prdata = cfg_high[1];
      REG_HIGH_Z: prdata = cfg_high[2];
      default: prdata = '0;
    endcase
  end

  logic [CW-1:0] ext [0:2];
  logic [2:0] ext_ok;
  axis_ctl_t ctl;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CW:0] d;
      d = (CW+1)'(cfg_high[a]) - (CW+1)'(cfg_low[a]);
      ext[a] = d[CW-1:0];
      ext_ok[a] = !d[CW] && (d != '0);
    end
    ctl.act = (cfg_mode != MODE_NONE) && cfg_bounds_valid && (&ext_ok);
    ctl.wrap_mode = cfg_mode == MODE_WRAP;
  end

  logic en;
  logic [DEPTH-1:0] vld;

  assign en = !vld[DEPTH-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] pos_in [0:2];
  logic signed [CW-1:0] vel_in [0:2];
  logic signed [CW-1:0] pos_out [0:2];
  logic signed [CW-1:0] vel_out [0:2];
  logic [2:0] outside;

  assign pos_in[0] = in_data.pos_x;
  assign pos_in[1] = in_data.pos_y;
  assign pos_in[2] = in_data.pos_z;
  assign vel_in[0] = in_data.vel_x;
  assign vel_in[1] = in_data.vel_y;
  assign vel_in[2] = in_data.vel_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    bbwr_axis #(.REFLECT_LIMIT(REFLECT_LIMIT)) u_axis (
      .clk(clk),
      .en(en),
      .ctl(ctl),
      .pos(pos_in[a]),
      .vel(vel_in[a]),
      .lo(cfg_low[a]),
      .hi(cfg_high[a]),
      .ext(ext[a]),
      .new_pos(pos_out[a]),
      .new_vel(vel_out[a]),
      .outside(outside[a])
    );
  end

  // changed only counts when the box was live; user must ensure config holds steady while busy, unenforced
  assign out_data.new_pos_x = pos_out[0];
  assign out_data.new_pos_y = pos_out[1];
  assign out_data.new_pos_z = pos_out[2];
  assign out_data.new_vel_x = vel_out[0];
  assign out_data.new_vel_y = vel_out[1];
  assign out_data.new_vel_z = vel_out[2];
  assign out_data.changed = ctl.act && (|outside);

  a_stall_only_when_full: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("input stalled without a blocked result");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_changed_needs_mode: assert property (@(posedge clk)
      out_valid && out_data.changed |-> cfg_mode != MODE_NONE && cfg_bounds_valid)
    else $error("changed flag while boundaries inactive");
  a_hold_under_stall: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(out_data.new_pos_x))
    else $error("stalled pipeline moved");

endmodule

// ===== dv/bbwr_checker.sv =====
`timescale 1ns / 100ps

module bbwr_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  bbwr_pkg::particle_in_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  bbwr_pkg::particle_out_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic pready,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output int errors,
  output int pending
);
  import bbwr_pkg::*;

  logic [1:0] mode_q;
  logic valid_q;
  logic signed [CW-1:0] lo_q [3];
  logic signed [CW-1:0] hi_q [3];
  particle_out_t confined_q [$];

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam int REFLECT_LIMIT_TB = 8;

  function automatic logic signed [CW-1:0] abs_sat(logic signed [CW-1:0] v);
    if (v >= 0) return v;
    if (v == {1'b1, {(CW-1){1'b0}}}) return MAXV;
    return -v;
  endfunction

  function automatic particle_out_t confine(particle_in_t p);
    particle_out_t r;
    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] vel [3];
    logic signed [63:0] v;
    logic signed [63:0] lo, hi, ext, d;
    logic on;
    logic chg;
    pos = '{p.pos_x, p.pos_y, p.pos_z};
    vel = '{p.vel_x, p.vel_y, p.vel_z};
    on = mode_q != MODE_NONE && valid_q;
    chg = 0;
    for (int a = 0; a < 3; a++)
      if (hi_q[a] <= lo_q[a]) on = 0;
    if (on) begin
      for (int a = 0; a < 3; a++) begin
        lo = lo_q[a];
        hi = hi_q[a];
        if (pos[a] >= lo_q[a] && pos[a] <= hi_q[a]) continue;
        chg = 1;
        if (mode_q == MODE_WRAP) begin
          ext = hi - lo;
          d = 64'(signed'(pos[a])) - lo;
          d = d % ext;
          if (d < 0) d = d + ext;
          pos[a] = CW'(lo + d);
          continue;
        end
        v = pos[a];
        // mirror exactly, the intermediate can leave the block width
        for (int g = 0; g < REFLECT_LIMIT_TB && (v < lo || v > hi); g++) begin
          if (v < lo) begin
            v = lo + (lo - v);
            vel[a] = abs_sat(vel[a]);
          end else begin
            v = hi - (v - hi);
            vel[a] = -abs_sat(vel[a]);
          end
        end
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        pos[a] = v[CW-1:0];
      end
    end
    r.new_pos_x = pos[0];
    r.new_pos_y = pos[1];
    r.new_pos_z = pos[2];
    r.new_vel_x = vel[0];
    r.new_vel_y = vel[1];
    r.new_vel_z = vel[2];
    r.changed = chg;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    particle_out_t e;
    if (rst) begin
      mode_q <= MODE_NONE;
      valid_q <= 0;
      lo_q <= '{default: '0};
      hi_q <= '{default: '0};
      errors <= 0;
      confined_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MODE: mode_q <= pwdata[1:0];
          REG_VALID: valid_q <= pwdata[0];
          REG_LOW_X, REG_LOW_Y, REG_LOW_Z: lo_q[paddr[4:2] - REG_LOW_X] <= pwdata;
          default: hi_q[paddr[4:2] - REG_HIGH_X] <= pwdata;
        endcase
      end
      if (in_valid && !in_stall) confined_q.push_back(confine(in_data));
      if (out_valid && !out_stall) begin
        if (confined_q.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          e = confined_q.pop_front();
          if (out_data.new_pos_x !== e.new_pos_x) report("pos_x", out_data.new_pos_x, e.new_pos_x);
          if (out_data.new_pos_y !== e.new_pos_y) report("pos_y", out_data.new_pos_y, e.new_pos_y);
          if (out_data.new_pos_z !== e.new_pos_z) report("pos_z", out_data.new_pos_z, e.new_pos_z);
          if (out_data.new_vel_x !== e.new_vel_x) report("vel_x", out_data.new_vel_x, e.new_vel_x);
          if (out_data.new_vel_y !== e.new_vel_y) report("vel_y", out_data.new_vel_y, e.new_vel_y);
          if (out_data.new_vel_z !== e.new_vel_z) report("vel_z", out_data.new_vel_z, e.new_vel_z);
          if (out_data.changed !== e.changed) report("changed", out_data.changed, e.changed);
        end
      end
    end
  end

  assign pending = confined_q.size();
endmodule

// ===== dv/tb_box_boundary_wrap_reflect.sv =====
`timescale 1ns / 100ps

module tb_box_boundary_wrap_reflect;
  import bbwr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  particle_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  particle_out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  logic [31:0] box_span;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  box_boundary_wrap_reflect dut (.*);

  bbwr_checker chk (.*);

  // receiver stall pattern
  always @(posedge clk) begin
    int ph;
    ph = int'(($time / 400) % 4);
    if (ph == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) < ph);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_box(logic [1:0] m, logic v, logic [31:0] lx, logic [31:0] hx,
                         logic [31:0] ly, logic [31:0] hy, logic [31:0] lz,
                         logic [31:0] hz);
    // drain: results out, then wait longer than the pipeline depth
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_VALID, {31'd0, v});
    write_reg(REG_LOW_X, lx);
    write_reg(REG_HIGH_X, hx);
    write_reg(REG_LOW_Y, ly);
    write_reg(REG_HIGH_Y, hy);
    write_reg(REG_LOW_Z, lz);
    write_reg(REG_HIGH_Z, hz);
  endtask

  task automatic send(particle_in_t p);
    in_valid <= 1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] near_box(logic [31:0] lo, logic [31:0] span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return lo + $urandom_range(0, 3) * span - $urandom_range(0, 8);
      2: return lo - $urandom_range(0, 3) * span + $urandom_range(0, 8);
      3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      default: return lo + $urandom % (span + 32'd1) +
                      ($urandom_range(0, 1) ? span * $urandom_range(1, 9) : 32'd0);
    endcase
  endfunction

  task automatic burst_of(int n, logic [31:0] lo, logic [31:0] span);
    particle_in_t p;
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--, left--) begin
        p.pos_x = near_box(lo, span);
        p.pos_y = near_box(lo, span);
        p.pos_z = near_box(lo, span);
        p.vel_x = $urandom;
        p.vel_y = $urandom_range(0, 7) == 0 ? 32'h8000_0000 : $urandom;
        p.vel_z = $urandom;
        send(p);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 0;
  endtask

  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

  initial begin
    particle_in_t p;
    logic [31:0] lo;
    repeat (11) @(posedge clk);
    rst <= 0;
    // reset config: pass-through
    p = '{SMIN, SMAX, 32'd0, SMIN, SMAX, 32'hFFFF_FFFF};
    send(p);
    in_valid <= 0;
    // wrap with full extremes on a small box
    set_box(MODE_WRAP, 1, 32'hFFFF_0000, 32'h0001_0000, 32'd0, 32'd5, 32'd100, 32'd101);
    send('{SMIN, SMAX, 32'd100, SMIN, 32'd1, 32'd2});
    send('{SMAX, SMIN, 32'd102, SMAX, 32'd0, 32'd0});
    send('{32'h0001_0000, 32'd5, 32'd101, 32'd0, 32'd0, 32'd0});
    send('{32'hFFFF_0000, 32'hFFFF_FFFF, 32'd99, 32'd0, 32'd0, 32'd0});
    in_valid <= 0;
    // reflect across the full range, limit reached, min velocity
    set_box(MODE_REFLECT, 1, SMIN, SMAX - 1, 32'd0, 32'd10, 32'hFFFF_FFF0, 32'd0);
    send('{SMAX, 32'd1000, 32'hFFFF_FF00, SMIN, SMIN, SMAX});
    send('{32'd5, 32'hFFFF_FFFF, 32'd3, SMAX, SMIN, SMIN});
    send('{SMIN, 32'd11, 32'hFFFF_FFEF, 32'd0, 32'd4, SMIN});
    in_valid <= 0;
    // unused mode value acts as reflect
    set_box(2'd3, 1, 32'd0, 32'd100, 32'd0, 32'd100, 32'd0, 32'd100);
    send('{32'd250, 32'hFFFF_FFCE, 32'd50, 32'd7, 32'hFFFF_FFF9, 32'd1});
    in_valid <= 0;
    // invalid box, zero extent, wide box
    set_box(MODE_WRAP, 0, 32'd0, 32'd100, 32'd0, 32'd100, 32'd0, 32'd100);
    send('{32'd250, 32'd250, 32'd250, 32'd1, 32'd1, 32'd1});
    in_valid <= 0;
    set_box(MODE_REFLECT, 1, 32'd0, 32'd100, 32'd7, 32'd7, 32'd0, 32'd100);
    send('{32'd250, 32'd250, 32'd250, 32'd1, 32'd1, 32'd1});
    in_valid <= 0;
    set_box(MODE_WRAP, 1, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);
    send('{SMIN, SMAX, 32'd0, 32'd1, 32'd1, 32'd1});
    in_valid <= 0;
    // random phases over modes and box sizes
    for (int ph = 0; ph < 14; ph++) begin
      lo = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000);
      box_span = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 32'h00FF_FFFF);
      set_box(ph % 5 == 4 ? MODE_NONE : (ph % 2 ? MODE_WRAP : MODE_REFLECT),
              ph != 9, lo, lo + box_span, lo, lo + box_span, lo, lo + box_span);
      burst_of(100, lo, box_span);
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
design/bbwr_pkg.sv
design/bbwr_axis.sv
design/box_boundary_wrap_reflect.sv
dv/bbwr_checker.sv
dv/tb_box_boundary_wrap_reflect.sv
